// File: rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Micro-operations, jump conditions, the control store and calendar tables.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int PC_BITS = 5;

	typedef logic [PC_BITS-1:0] gda_pc_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV100,
		OP_CHECK,
		OP_WSUM,
		OP_WMOD,
		OP_SUNDAY,
		OP_ADDN,
		OP_DAYSTEP,
		OP_MQUOT,
		OP_MAPPLY,
		OP_CLAMP,
		OP_YAPPLY,
		OP_LEAPFIX,
		OP_RESTORE,
		OP_YDAY,
		OP_DONE
	} gda_op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NOIN,
		C_INVALID,
		C_KDAYS,
		C_KMONTHS,
		C_KYEARS,
		C_MORE,
		C_OUTFREE
	} gda_cond_t;

	typedef enum logic [1:0] {
		K_DAYS,
		K_MONTHS,
		K_YEARS,
		K_SUNDAY
	} gda_kind_t;

	typedef enum logic [1:0] {
		E_OK,
		E_INVALID,
		E_OVERFLOW
	} gda_err_t;

	typedef struct packed {
		gda_op_t   op;
		gda_cond_t cond;
		gda_pc_t   target;
	} gda_uword_t;

	typedef struct packed {
		logic      invalid;
		gda_kind_t kind;
		logic      more;
		logic      out_free;
	} gda_stat_t;

	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam int          OUT_W      = 40;

	localparam gda_pc_t A_IDLE = 5'd0;
	localparam gda_pc_t A_ADDN = 5'd9;
	localparam gda_pc_t A_LOOP = 5'd10;
	localparam gda_pc_t A_MON  = 5'd12;
	localparam gda_pc_t A_YR   = 5'd16;
	localparam gda_pc_t A_FIN  = 5'd19;
	localparam gda_pc_t A_DONE = 5'd24;

	function automatic gda_uword_t uw(input gda_op_t op, input gda_cond_t cond,
		input gda_pc_t target);
		gda_uword_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// Control store. Each word runs one datapath operation and jumps to its
	// target when the condition holds, otherwise it falls through.
	function automatic gda_uword_t ucode(input gda_pc_t pc);
		gda_uword_t w;
		unique case (pc)
			5'd0:    w = uw(OP_LOAD,    C_NOIN,    A_IDLE);
			5'd1:    w = uw(OP_DIV100,  C_NONE,    A_IDLE);
			5'd2:    w = uw(OP_CHECK,   C_INVALID, A_DONE);
			5'd3:    w = uw(OP_NOP,     C_KDAYS,   A_ADDN);
			5'd4:    w = uw(OP_NOP,     C_KMONTHS, A_MON);
			5'd5:    w = uw(OP_NOP,     C_KYEARS,  A_YR);
			5'd6:    w = uw(OP_WSUM,    C_NONE,    A_IDLE);
			5'd7:    w = uw(OP_WMOD,    C_NONE,    A_IDLE);
			5'd8:    w = uw(OP_SUNDAY,  C_ALWAYS,  A_LOOP);
			5'd9:    w = uw(OP_ADDN,    C_NONE,    A_IDLE);
			5'd10:   w = uw(OP_DAYSTEP, C_MORE,    A_LOOP);
			5'd11:   w = uw(OP_NOP,     C_ALWAYS,  A_FIN);
			5'd12:   w = uw(OP_MQUOT,   C_NONE,    A_IDLE);
			5'd13:   w = uw(OP_MAPPLY,  C_NONE,    A_IDLE);
			5'd14:   w = uw(OP_DIV100,  C_NONE,    A_IDLE);
			5'd15:   w = uw(OP_CLAMP,   C_ALWAYS,  A_FIN);
			5'd16:   w = uw(OP_YAPPLY,  C_NONE,    A_IDLE);
			5'd17:   w = uw(OP_DIV100,  C_NONE,    A_IDLE);
			5'd18:   w = uw(OP_LEAPFIX, C_NONE,    A_IDLE);
			5'd19:   w = uw(OP_RESTORE, C_NONE,    A_IDLE);
			5'd20:   w = uw(OP_DIV100,  C_NONE,    A_IDLE);
			5'd21:   w = uw(OP_WSUM,    C_NONE,    A_IDLE);
			5'd22:   w = uw(OP_WMOD,    C_NONE,    A_IDLE);
			5'd23:   w = uw(OP_YDAY,    C_NONE,    A_IDLE);
			5'd24:   w = uw(OP_DONE,    C_OUTFREE, A_IDLE);
			5'd25:   w = uw(OP_NOP,     C_ALWAYS,  A_DONE);
			default: w = uw(OP_NOP,     C_ALWAYS,  A_IDLE);
		endcase
		return w;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	// Month term of the congruence, (13 * mm - 1) / 5 with March as month one.
	function automatic logic [4:0] zeller_month(input logic [3:0] m);
		logic [4:0] v;
		case (m)
			4'd1:    v = 5'd28;
			4'd2:    v = 5'd31;
			4'd3:    v = 5'd2;
			4'd4:    v = 5'd5;
			4'd5:    v = 5'd7;
			4'd6:    v = 5'd10;
			4'd7:    v = 5'd12;
			4'd8:    v = 5'd15;
			4'd9:    v = 5'd18;
			4'd10:   v = 5'd20;
			4'd11:   v = 5'd23;
			default: v = 5'd25;
		endcase
		return v;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd2:    v = 9'd31;
			4'd3:    v = 9'd59;
			4'd4:    v = 9'd90;
			4'd5:    v = 9'd120;
			4'd6:    v = 9'd151;
			4'd7:    v = 9'd181;
			4'd8:    v = 9'd212;
			4'd9:    v = 9'd243;
			4'd10:   v = 9'd273;
			4'd11:   v = 9'd304;
			4'd12:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/gda_seq.sv
// ----------------------------------------------------------------------------
// Gregorian date adder sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module gda_seq import gda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  gda_stat_t stat,
	output gda_op_t   op,
	output logic      in_ready
);

	gda_pc_t    pc_q;
	gda_pc_t    pc_next;
	gda_uword_t word;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_comb begin
		word = ucode(pc_q);
		unique case (word.cond)
			C_NONE:    take = 1'b0;
			C_ALWAYS:  take = 1'b1;
			C_NOIN:    take = !in_valid;
			C_INVALID: take = stat.invalid;
			C_KDAYS:   take = stat.kind == K_DAYS;
			C_KMONTHS: take = stat.kind == K_MONTHS;
			C_KYEARS:  take = stat.kind == K_YEARS;
			C_MORE:    take = stat.more;
			C_OUTFREE: take = stat.out_free;
			default:   take = 1'b1;
		endcase
		pc_next  = take ? word.target : pc_q + gda_pc_t'(1);
		op       = word.op;
		in_ready = word.op == OP_LOAD;
	end

endmodule

// File: rtl/gda_dp.sv
// ----------------------------------------------------------------------------
// Gregorian date adder datapath
// Date registers, century split, weekday and ordinal day units, result register.
// ----------------------------------------------------------------------------
module gda_dp import gda_pkg::*; #(
	parameter int AMOUNT_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gda_op_t                op,
	input  logic                   in_load,
	input  gda_kind_t              in_kind,
	input  logic [13:0]            in_year,
	input  logic [3:0]             in_month,
	input  logic [4:0]             in_day,
	input  logic [AMOUNT_BITS-1:0] in_amount,
	input  logic                   out_ready,
	output gda_stat_t              stat,
	output logic                   out_valid,
	output logic [13:0]            out_year,
	output logic [3:0]             out_month,
	output logic [4:0]             out_day,
	output logic [2:0]             out_wday,
	output logic [8:0]             out_yday,
	output gda_err_t               out_err
);

	localparam int DW  = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;
	localparam int TW  = AMOUNT_BITS + 1;
	localparam int XW  = AMOUNT_BITS - 1;
	localparam int PW  = XW + 16;
	localparam int YSW = ((AMOUNT_BITS > 14) ? AMOUNT_BITS : 14) + 1;

	gda_kind_t              kind_q;
	logic [13:0]            y0_q;
	logic [3:0]             m0_q;
	logic [4:0]             d0_q;
	logic [AMOUNT_BITS-1:0] n_q;
	logic [13:0]            y_q;
	logic [3:0]             m_q;
	logic [DW-1:0]          d_q;
	logic [7:0]             c_q;
	logic [6:0]             r_q;
	logic [9:0]             f_q;
	logic [2:0]             wd_q;
	logic [8:0]             yd_q;
	logic [AMOUNT_BITS-1:0] q_q;
	logic [TW-1:0]          t_q;
	logic                   ovf_q;
	gda_err_t               err_q;

	logic                   out_valid_q;
	logic [13:0]            out_year_q;
	logic [3:0]             out_month_q;
	logic [4:0]             out_day_q;
	logic [2:0]             out_wday_q;
	logic [8:0]             out_yday_q;
	gda_err_t               out_err_q;

	logic                   leap;
	logic [4:0]             len;
	logic                   invalid;
	logic                   more_raw;
	logic                   wrap;
	logic                   ovf_step;
	logic                   out_free;
	logic [26:0]            prod_y;
	logic [7:0]             c_new;
	logic [14:0]            c100;
	logic [14:0]            r_full;
	logic [7:0]             c_dec;
	logic [6:0]             r_dec;
	logic [9:0]             f_sum;
	logic [21:0]            prod_f;
	logic [7:0]             q7;
	logic [10:0]            q7x7;
	logic [10:0]            wd_full;
	logic [8:0]             yd_new;
	logic [TW-1:0]          t_sum;
	logic [XW-1:0]          x_t;
	logic [PW-1:0]          prod_t;
	logic [TW-1:0]          q12;
	logic [TW-1:0]          rem;
	logic [YSW-1:0]         ny_m;
	logic [YSW-1:0]         ny_y;

	always_comb begin
		leap     = (r_q != 7'd0) ? (r_q[1:0] == 2'd0) : (c_q[1:0] == 2'd0);
		len      = month_len(m_q, leap);
		invalid  = y_q == 14'd0 || y_q > YEAR_MAX || m_q == 4'd0 || m_q > MONTH_LAST ||
			d_q == DW'(0) || d_q > DW'(len);
		more_raw = d_q > DW'(len);
		wrap     = m_q == MONTH_LAST;
		ovf_step = wrap && y_q == YEAR_MAX;
		out_free = !out_valid_q || out_ready;

		prod_y = 27'(y_q) * 27'd5243;
		c_new  = prod_y[26:19];
		c100   = 15'(c_new) * 15'd100;
		r_full = 15'(y_q) - c100;

		if (m_q < 4'd3 && r_q == 7'd0) begin
			c_dec = c_q - 8'd1;
			r_dec = 7'd99;
		end else if (m_q < 4'd3) begin
			c_dec = c_q;
			r_dec = r_q - 7'd1;
		end else begin
			c_dec = c_q;
			r_dec = r_q;
		end
		f_sum = 10'(d_q[4:0]) + 10'(zeller_month(m_q)) + 10'(r_dec) + 10'(r_dec[6:2]) +
			10'(c_dec[7:2]) + {c_dec, 2'b00} + 10'(c_dec);

		prod_f  = 22'(f_q) * 22'd2341;
		q7      = prod_f[21:14];
		q7x7    = {q7, 3'b000} - 11'(q7);
		wd_full = 11'(f_q) - q7x7;

		yd_new = days_before(m_q) + 9'(leap && m_q > 4'd2) + 9'(d_q[4:0]);

		t_sum  = TW'(m_q) + TW'(n_q) - TW'(1);
		x_t    = t_sum[TW-1:2];
		prod_t = PW'(x_t) * PW'(17'd43691);
		q12    = TW'({q_q, 3'b000}) + TW'({q_q, 2'b00});
		rem    = t_q - q12;
		ny_m   = YSW'(y_q) + YSW'(q_q);
		ny_y   = YSW'(y_q) + YSW'(n_q);

		stat.invalid  = invalid;
		stat.kind     = kind_q;
		stat.more     = more_raw && !ovf_step;
		stat.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (in_load) begin
					kind_q <= in_kind;
					y0_q   <= in_year;
					m0_q   <= in_month;
					d0_q   <= in_day;
					n_q    <= in_amount;
					y_q    <= in_year;
					m_q    <= in_month;
					d_q    <= DW'(in_day);
					ovf_q  <= 1'b0;
					err_q  <= E_OK;
					wd_q   <= 3'd0;
					yd_q   <= 9'd0;
				end
			end
			OP_DIV100: begin
				c_q <= c_new;
				r_q <= r_full[6:0];
			end
			OP_CHECK: begin
				if (invalid) begin
					err_q <= E_INVALID;
				end
			end
			OP_WSUM: begin
				f_q <= f_sum;
			end
			OP_WMOD: begin
				wd_q <= wd_full[2:0];
			end
			OP_SUNDAY: begin
				d_q <= d_q + DW'(7) - DW'(wd_q);
			end
			OP_ADDN: begin
				d_q <= d_q + DW'(n_q);
			end
			OP_DAYSTEP: begin
				if (more_raw) begin
					if (ovf_step) begin
						ovf_q <= 1'b1;
					end else begin
						d_q <= d_q - DW'(len);
						m_q <= wrap ? 4'd1 : m_q + 4'd1;
						if (wrap) begin
							y_q <= y_q + 14'd1;
							if (r_q == 7'd99) begin
								r_q <= 7'd0;
								c_q <= c_q + 8'd1;
							end else begin
								r_q <= r_q + 7'd1;
							end
						end
					end
				end
			end
			OP_MQUOT: begin
				t_q <= t_sum;
				q_q <= AMOUNT_BITS'(prod_t[PW-1:17]);
			end
			OP_MAPPLY: begin
				if (ny_m > YSW'(YEAR_MAX)) begin
					ovf_q <= 1'b1;
				end else begin
					y_q <= ny_m[13:0];
					m_q <= rem[3:0] + 4'd1;
				end
			end
			OP_CLAMP: begin
				if (more_raw) begin
					d_q <= DW'(len);
				end
			end
			OP_YAPPLY: begin
				if (ny_y > YSW'(YEAR_MAX)) begin
					ovf_q <= 1'b1;
				end else begin
					y_q <= ny_y[13:0];
				end
			end
			OP_LEAPFIX: begin
				if (m_q == 4'd2 && d_q == DW'(29) && !leap) begin
					m_q <= 4'd3;
					d_q <= DW'(1);
				end
			end
			OP_RESTORE: begin
				if (ovf_q) begin
					y_q   <= y0_q;
					m_q   <= m0_q;
					d_q   <= DW'(d0_q);
					err_q <= E_OVERFLOW;
				end
			end
			OP_YDAY: begin
				yd_q <= yd_new;
			end
			OP_DONE: begin
				if (out_free) begin
					out_year_q  <= y_q;
					out_month_q <= m_q;
					out_day_q   <= d_q[4:0];
					out_wday_q  <= wd_q;
					out_yday_q  <= yd_q;
					out_err_q   <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_year  = out_year_q;
	assign out_month = out_month_q;
	assign out_day   = out_day_q;
	assign out_wday  = out_wday_q;
	assign out_yday  = out_yday_q;
	assign out_err   = out_err_q;

endmodule

// File: rtl/gregorian_date_adder.sv
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds days, months or years to a date, or moves it to the next Sunday, and
// reports the day of week, the day of year and an error code.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (from bit 0 up)
//  s_*       in         kind, year_in, month_in, day_in, amount
//  m_*       out        year_out, month_out, day_out, weekday, year_day, error_code
//
// One item at a time. An invalid date goes from the check straight to the completion step;
// for days the loop crosses one month boundary per step, and this day loop sets the worst
// case. The input is ready again in the cycle after the result is loaded, even while it
// waits. While the result register is full the sequencer alternates between its
// completion step and a wait step that jumps back to it. Reset clears the step counter and
// valid flag.
// ----------------------------------------------------------------------------
module gregorian_date_adder import gda_pkg::*; #(
	parameter int AMOUNT_BITS = 12,
	localparam int IN_W = ((25 + AMOUNT_BITS + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,   // kind, year_in, month_in, day_in, amount
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OUT_W-1:0] m_tdata   // year_out, month_out, day_out, weekday,
	                                    // year_day, error_code
);

	gda_op_t    op;
	gda_stat_t  stat;
	logic       in_load;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [2:0]  out_wday;
	logic [8:0]  out_yday;
	gda_err_t    out_err;

	assign in_load = s_tvalid && s_tready;

	gda_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.op       (op),
		.in_ready (s_tready)
	);

	gda_dp #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_load   (in_load),
		.in_kind   (gda_kind_t'(s_tdata[1:0])),
		.in_year   (s_tdata[15:2]),
		.in_month  (s_tdata[19:16]),
		.in_day    (s_tdata[24:20]),
		.in_amount (s_tdata[25 +: AMOUNT_BITS]),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_year  (out_year),
		.out_month (out_month),
		.out_day   (out_day),
		.out_wday  (out_wday),
		.out_yday  (out_yday),
		.out_err   (out_err)
	);

	assign m_tdata = {3'b000, out_err, out_yday, out_wday, out_day, out_month, out_year};

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_invalid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_err == E_INVALID |-> out_wday == 3'd0 && out_yday == 9'd0)
		else $error("invalid date result carries weekday or day of year");

	a_valid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_err != E_INVALID |-> out_wday < 3'd7 && out_yday != 9'd0 &&
		out_yday <= 9'd366 && out_month != 4'd0 && out_month <= 4'd12 && out_day != 5'd0)
		else $error("result date out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_err == E_OK |-> out_year != 14'd0 && out_year <= YEAR_MAX)
		else $error("result year out of range");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(op == OP_DONE))
		else $error("result raised outside the completion step");
`endif

endmodule

// File: sim/tb_gregorian_date_adder.sv
// ----------------------------------------------------------------------------
// Gregorian date adder testbench
// Sends date operations of every kind, including invalid dates and overflows,
// predicts each result in the scoreboard and checks the returned fields.
// ----------------------------------------------------------------------------
module tb_gregorian_date_adder;
	import gda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		gda_kind_t   kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [11:0] amount;
	} date_op_t;

	typedef struct {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [8:0]  year_day;
		gda_err_t    err;
	} date_res_t;

	class date_scoreboard;
		date_res_t   pending_q[$];
		int          mismatches;
		int          checked;
		int          kind_count[4];
		int          err_count[3];

		function bit leap_year(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function int unsigned month_days(int unsigned y, int unsigned m);
			case (m)
				2:             return leap_year(y) ? 29 : 28;
				4, 6, 9, 11:   return 30;
				default:       return 31;
			endcase
		endfunction

		function int unsigned zeller_weekday(int unsigned y, int unsigned m, int unsigned d);
			int unsigned mm;
			int unsigned yy;
			mm = (m < 3) ? m + 10 : m - 2;
			yy = (mm > 10) ? y - 1 : y;
			return (d + (13 * mm - 1) / 5 + yy % 100 + (yy % 100) / 4 + (yy / 100) / 4
				+ 5 * (yy / 100)) % 7;
		endfunction

		function int unsigned ordinal_in_year(int unsigned y, int unsigned m, int unsigned d);
			int unsigned total;
			total = d;
			for (int unsigned i = 1; i < m; i++)
				total += month_days(y, i);
			return total;
		endfunction

		function bit advance_days(inout int unsigned y, inout int unsigned m,
			inout int unsigned d, input int unsigned n);
			d += n;
			while (d > month_days(y, m)) begin
				d -= month_days(y, m);
				m++;
				if (m > 12) begin
					m = 1;
					y++;
					if (y > 9999)
						return 0;
				end
			end
			return 1;
		endfunction

		function date_res_t compute_date(date_op_t op);
			date_res_t   r;
			int unsigned y;
			int unsigned m;
			int unsigned d;
			int unsigned n;
			int unsigned t;
			bit          ok;
			y  = op.year;
			m  = op.month;
			d  = op.day;
			n  = op.amount;
			ok = 1;
			r.weekday  = '0;
			r.year_day = '0;
			r.err      = E_OK;
			if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
				r.err = E_INVALID;
			end else begin
				case (op.kind)
					K_DAYS: begin
						ok = advance_days(y, m, d, n);
					end
					K_MONTHS: begin
						t = m - 1 + n;
						if (y + t / 12 > 9999) begin
							ok = 0;
						end else begin
							y = y + t / 12;
							m = t % 12 + 1;
							if (d > month_days(y, m))
								d = month_days(y, m);
						end
					end
					K_YEARS: begin
						if (y + n > 9999) begin
							ok = 0;
						end else if (n != 0) begin
							if (m == 2 && d == 29 && !leap_year(y + n)) begin
								m = 3;
								d = 1;
							end
							y = y + n;
						end
					end
					default: begin
						ok = advance_days(y, m, d, 7 - zeller_weekday(y, m, d));
					end
				endcase
				if (!ok) begin
					r.err = E_OVERFLOW;
					y = op.year;
					m = op.month;
					d = op.day;
				end
				r.weekday  = 3'(zeller_weekday(y, m, d));
				r.year_day = 9'(ordinal_in_year(y, m, d));
			end
			r.year  = 14'(y);
			r.month = 4'(m);
			r.day   = 5'(d);
			return r;
		endfunction

		function void note_input(date_op_t op);
			date_res_t r;
			r = compute_date(op);
			kind_count[op.kind]++;
			err_count[r.err]++;
			pending_q.push_back(r);
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t ns mismatch: %s", $realtime, msg);
		endtask

		task check_result(date_res_t got);
			date_res_t want;
			string     diff;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result %0d-%0d-%0d err %0d", got.year,
					got.month, got.day, got.err));
				return;
			end
			want = pending_q.pop_front();
			checked++;
			diff = "";
			if (got.year !== want.year)
				diff = {diff, " year"};
			if (got.month !== want.month)
				diff = {diff, " month"};
			if (got.day !== want.day)
				diff = {diff, " day"};
			if (got.weekday !== want.weekday)
				diff = {diff, " weekday"};
			if (got.year_day !== want.year_day)
				diff = {diff, " year_day"};
			if (got.err !== want.err)
				diff = {diff, " error_code"};
			if (diff != "")
				report({$sformatf("result %0d,%s: got %0d-%0d-%0d wd %0d yd %0d err %0d",
					checked, diff, got.year, got.month, got.day, got.weekday,
					got.year_day, got.err),
					$sformatf(", expected %0d-%0d-%0d wd %0d yd %0d err %0d",
					want.year, want.month, want.day, want.weekday, want.year_day,
					want.err)});
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	bit             sender_idle;
	bit             receiver_idle;
	date_scoreboard sb = new();

	gregorian_date_adder #(
		.AMOUNT_BITS(12)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic date_op_t make_op(gda_kind_t kind, int y, int m, int d, int n);
		date_op_t op;
		op.kind   = kind;
		op.year   = 14'(y);
		op.month  = 4'(m);
		op.day    = 5'(d);
		op.amount = 12'(n);
		return op;
	endfunction

	function automatic date_op_t random_op();
		date_op_t op;
		op.kind = gda_kind_t'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			op.year  = 14'($urandom_range(0, 16383));
			op.month = 4'($urandom_range(0, 15));
			op.day   = 5'($urandom_range(0, 31));
		end else begin
			case ($urandom_range(0, 9))
				0:       op.year = 14'($urandom_range(9990, 9999));
				1:       op.year = 14'($urandom_range(1, 20));
				default: op.year = 14'($urandom_range(1, 9999));
			endcase
			op.month = 4'($urandom_range(1, 12));
			op.day   = 5'($urandom_range(1, sb.month_days(op.year, op.month)));
		end
		case ($urandom_range(0, 3))
			0:       op.amount = 12'($urandom_range(0, 3));
			1:       op.amount = 12'($urandom_range(0, 40));
			default: op.amount = 12'($urandom_range(0, 4095));
		endcase
		return op;
	endfunction

	task automatic send_op(date_op_t op);
		if (sender_idle && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		s_tdata  = {3'b000, op.amount, op.day, op.month, op.year, op.kind};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(op);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin : receiver
		int stall;
		stall    = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				stall    = $urandom_range(1, 8) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		date_res_t r;
		if (arst_n && m_tvalid && m_tready) begin
			r.year     = m_tdata[13:0];
			r.month    = m_tdata[17:14];
			r.day      = m_tdata[22:18];
			r.weekday  = m_tdata[25:23];
			r.year_day = m_tdata[34:26];
			r.err      = gda_err_t'(m_tdata[36:35]);
			sb.check_result(r);
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		date_op_t directed[$];
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed.push_back(make_op(K_DAYS,    2024, 1, 31, 1));
		directed.push_back(make_op(K_DAYS,    2024, 2, 28, 1));
		directed.push_back(make_op(K_DAYS,    1999, 12, 31, 1));
		directed.push_back(make_op(K_DAYS,    1, 1, 1, 0));
		directed.push_back(make_op(K_DAYS,    9999, 12, 31, 1));
		directed.push_back(make_op(K_DAYS,    1, 1, 1, 4095));
		directed.push_back(make_op(K_DAYS,    9999, 12, 31, 0));
		directed.push_back(make_op(K_MONTHS,  2024, 1, 31, 1));
		directed.push_back(make_op(K_MONTHS,  2023, 1, 31, 1));
		directed.push_back(make_op(K_MONTHS,  2024, 2, 29, 12));
		directed.push_back(make_op(K_MONTHS,  9999, 12, 15, 1));
		directed.push_back(make_op(K_MONTHS,  2020, 5, 15, 4095));
		directed.push_back(make_op(K_YEARS,   2024, 2, 29, 1));
		directed.push_back(make_op(K_YEARS,   2024, 2, 29, 4));
		directed.push_back(make_op(K_YEARS,   9000, 1, 1, 999));
		directed.push_back(make_op(K_YEARS,   9000, 1, 1, 1000));
		directed.push_back(make_op(K_YEARS,   1, 1, 1, 4095));
		directed.push_back(make_op(K_SUNDAY,  2024, 3, 3, 0));
		directed.push_back(make_op(K_SUNDAY,  2024, 3, 2, 4095));
		directed.push_back(make_op(K_SUNDAY,  9999, 12, 31, 0));
		directed.push_back(make_op(K_DAYS,    0, 6, 10, 5));
		directed.push_back(make_op(K_MONTHS,  16383, 15, 31, 1));
		directed.push_back(make_op(K_YEARS,   2023, 0, 10, 1));
		directed.push_back(make_op(K_SUNDAY,  2023, 2, 29, 0));
		directed.push_back(make_op(K_DAYS,    2100, 2, 29, 1));
		directed.push_back(make_op(K_MONTHS,  2024, 4, 0, 2));
		foreach (directed[i])
			send_op(directed[i]);
		drain();

		for (int i = 0; i < 1450; i++) begin
			if (i == 700)
				drain();
			if (i == 1250) begin
				sender_idle   = 1'b0;
				receiver_idle = 1'b0;
			end
			send_op(random_op());
		end
		drain();
		repeat (200) @(posedge clk);

		$display("Checked %0d results: %0d add-days, %0d add-months, %0d add-years, %0d %s",
			sb.checked, sb.kind_count[K_DAYS], sb.kind_count[K_MONTHS],
			sb.kind_count[K_YEARS], sb.kind_count[K_SUNDAY], "next-Sunday.");
		$display("Outcomes: %0d valid, %0d invalid dates, %0d year overflows; %0d %s",
			sb.err_count[E_OK], sb.err_count[E_INVALID], sb.err_count[E_OVERFLOW],
			sb.mismatches, "mismatches.");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
